// ===== rtl/core/alke_pkg.sv =====
// ----------------------------------------------------------------------------
// alke_pkg
// Shared types and constants for the ladder keypad event core: register
// indexes, event codes, phase codes and the command passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package alke_pkg;

   // Field widths
   localparam int unsigned VOLT_W  = 12;
   localparam int unsigned TOL_W   = 10;
   localparam int unsigned DEB_W   = 10;
   localparam int unsigned TIME_W  = 16;
   localparam int unsigned KEY_W   = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Keys that have a level register
   localparam int unsigned LEVEL_REGS = 4;

   // Press time added per tick
   localparam logic [TIME_W-1:0] TICK_MS = 16'd10;

   // Command queue depth between front and back
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;
   localparam int unsigned Q_CNT_W = 3;

   // Register reset values
   localparam logic [VOLT_W-1:0] KEY0_RESET    = 12'd400;
   localparam logic [VOLT_W-1:0] KEY1_RESET    = 12'd1000;
   localparam logic [VOLT_W-1:0] KEY2_RESET    = 12'd1600;
   localparam logic [VOLT_W-1:0] KEY3_RESET    = 12'd2200;
   localparam logic [TOL_W-1:0]  TOL_RESET     = 10'd100;
   localparam logic [VOLT_W-1:0] RELEASE_RESET = 12'd3000;
   localparam logic [DEB_W-1:0]  DEB_RESET     = 10'd30;
   localparam logic [TIME_W-1:0] LONG_RESET    = 16'd1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KEY0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOL     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEB     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LONG    = 3'd7;

   // Event codes on the result channel
   typedef enum logic [1:0] {
      EV_DOWN  = 2'd0,
      EV_LONG  = 2'd1,
      EV_CLICK = 2'd2,
      EV_UP    = 2'd3
   } ev_kind_type;

   // Key phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_DEBOUNCE = 4'b0010,
      PH_PRESSED  = 4'b0100,
      PH_WAIT     = 4'b1000
   } phase_type;

   // One queued command: a single event, or click followed by up when pair is set
   typedef struct packed {
      logic              pair;
      ev_kind_type       kind;
      logic [KEY_W-1:0]  key;
   } cmd_type;

endpackage : alke_pkg

`default_nettype wire

// ===== rtl/core/alke_front.sv =====
// ----------------------------------------------------------------------------
// alke_front
// Holds the configuration registers, decodes each request's voltage into a
// key, runs the press state machine and emits event commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module alke_front #(
   parameter int unsigned NUM_KEYS = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [alke_pkg::VOLT_W-1:0]      ladder_mv,
   input  wire logic                             csr_we,
   input  wire logic [alke_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [alke_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                                  cmd_push,
   output alke_pkg::cmd_type                     cmd
);
   import alke_pkg::*;

   localparam int unsigned NUM_MATCH = (NUM_KEYS < LEVEL_REGS) ? NUM_KEYS : LEVEL_REGS;

   logic [VOLT_W-1:0] level_ff [LEVEL_REGS];
   logic [TOL_W-1:0]  tol_ff;
   logic [VOLT_W-1:0] release_ff;
   logic [DEB_W-1:0]  deb_ff;
   logic [TIME_W-1:0] long_ff;

   phase_type         phase_ff, phase_in;
   logic [KEY_W-1:0]  held_ff, held_in;
   logic [TIME_W-1:0] time_ff, time_in;

   logic              have;
   logic [KEY_W-1:0]  key;
   logic              same;
   logic [TIME_W:0]   time_sum;
   logic [TIME_W-1:0] time_sat;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff[0] <= KEY0_RESET;
         level_ff[1] <= KEY1_RESET;
         level_ff[2] <= KEY2_RESET;
         level_ff[3] <= KEY3_RESET;
         tol_ff      <= TOL_RESET;
         release_ff  <= RELEASE_RESET;
         deb_ff      <= DEB_RESET;
         long_ff     <= LONG_RESET;
      end else if (csr_we) begin
         unique case (csr_index) inside
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
               level_ff[csr_index[1:0]] <= csr_wdata[VOLT_W-1:0];
            end
            REG_TOL:     tol_ff     <= csr_wdata[TOL_W-1:0];
            REG_RELEASE: release_ff <= csr_wdata[VOLT_W-1:0];
            REG_DEB:     deb_ff     <= csr_wdata[DEB_W-1:0];
            REG_LONG:    long_ff    <= csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Decode the sample: lowest key whose window holds it, unless above release
   always_comb begin
      logic [VOLT_W:0] v_ext;
      logic [VOLT_W:0] lvl_ext;
      logic [VOLT_W:0] tol_ext;
      have = 1'b0;
      key  = '0;
      v_ext   = {1'b0, ladder_mv};
      tol_ext = (VOLT_W+1)'(tol_ff);
      for (int i = 0; i < NUM_MATCH; i++) begin
         lvl_ext = {1'b0, level_ff[i]};
         if (!have && (v_ext + tol_ext >= lvl_ext) && (v_ext <= lvl_ext + tol_ext)) begin
            have = 1'b1;
            key  = KEY_W'(i);
         end
      end
      if (ladder_mv > release_ff) begin
         have = 1'b0;
      end
   end

   assign same     = have && (key == held_ff);
   assign time_sum = {1'b0, time_ff} + {1'b0, TICK_MS};
   assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

   // Advance the press state machine on each accepted request
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      time_in  = time_ff;
      cmd_push = 1'b0;
      cmd.pair = 1'b0;
      cmd.kind = EV_DOWN;
      cmd.key  = held_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (have) begin
                  held_in  = key;
                  time_in  = '0;
                  phase_in = PH_DEBOUNCE;
               end
            end
            PH_DEBOUNCE: begin
               time_in = time_sat;
               if (same) begin
                  if (time_sat >= TIME_W'(deb_ff)) begin
                     phase_in = PH_PRESSED;
                     cmd_push = 1'b1;
                     cmd.kind = EV_DOWN;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_PRESSED: begin
               if (same) begin
                  time_in = time_sat;
                  if (time_sat >= long_ff) begin
                     phase_in = PH_WAIT;
                     cmd_push = 1'b1;
                     cmd.kind = EV_LONG;
                  end
               end else if (!have) begin
                  phase_in = PH_IDLE;
                  cmd_push = 1'b1;
                  cmd.kind = EV_CLICK;
                  cmd.pair = 1'b1;
               end
            end
            PH_WAIT: begin
               if (!have) begin
                  phase_in = PH_IDLE;
                  cmd_push = 1'b1;
                  cmd.kind = EV_UP;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Hold machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
         time_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         time_ff  <= time_in;
      end
   end

endmodule : alke_front

`default_nettype wire

// ===== rtl/core/alke_queue.sv =====
// ----------------------------------------------------------------------------
// alke_queue
// Short command queue that decouples the state machine from result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module alke_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire alke_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output alke_pkg::cmd_type      head
);
   import alke_pkg::*;

   cmd_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Occupancy never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue occupancy above depth");

endmodule : alke_queue

`default_nettype wire

// ===== rtl/core/alke_back.sv =====
// ----------------------------------------------------------------------------
// alke_back
// Takes commands from the queue and presents their events on the result
// channel, splitting a click command into click then up.
// ----------------------------------------------------------------------------
`default_nettype none

module alke_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wire alke_pkg::cmd_type            q_head,
   output logic                              q_pop,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic [1:0]                        rsp_event_kind,
   output logic [alke_pkg::KEY_W-1:0]        rsp_key_index,
   output logic                              rsp_last
);
   import alke_pkg::*;

   cmd_type cmd_ff, cmd_in;
   logic    valid_ff, valid_in;
   logic    second_ff, second_in;
   logic    taken;
   logic    finish;

   assign rsp_empty      = !valid_ff;
   assign rsp_event_kind = second_ff ? EV_UP : cmd_ff.kind;
   assign rsp_key_index  = cmd_ff.key;
   assign rsp_last       = !cmd_ff.pair || second_ff;

   assign taken  = valid_ff && rsp_pop;
   assign finish = taken && rsp_last;
   assign q_pop  = !q_empty && (!valid_ff || finish);

   // Load the next command or step to the second event
   always_comb begin
      cmd_in    = cmd_ff;
      valid_in  = valid_ff;
      second_in = second_ff;
      if (q_pop) begin
         cmd_in    = q_head;
         valid_in  = 1'b1;
         second_in = 1'b0;
      end else if (finish) begin
         valid_in  = 1'b0;
         second_in = 1'b0;
      end else if (taken) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // Second event only exists inside a held click command
   a_second_in_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (valid_ff && cmd_ff.pair))
      else $error("second event without a click command");

   // A paired command always starts with click
   a_pair_is_click: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && cmd_ff.pair) |-> (cmd_ff.kind == EV_CLICK))
      else $error("paired command is not a click");

   // Taking the click puts up on the channel next
   a_click_then_up: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && cmd_ff.pair && !second_ff && rsp_pop)
      |=> (!rsp_empty && (rsp_event_kind == EV_UP) && rsp_last))
      else $error("up did not follow click");

endmodule : alke_back

`default_nettype wire

// ===== rtl/core/adc_ladder_key_event_fsm_core.sv =====
// ----------------------------------------------------------------------------
// adc_ladder_key_event_fsm_core
// Resistor ladder keypad decoder with debounce, long press, click and up
// events. One request is one tick; each causes zero, one or two results.
// ----------------------------------------------------------------------------
// Path: a request's command is queued at the accepting edge and loaded into the
//   back end register once that register holds no pending result.
// Throughput: one request per cycle while the 4-entry command queue has room;
//   the back end delivers one result per cycle while rsp_pop is held, a click as click then up.
// Reset: synchronous; registers return to their reset levels, the machine to
//   idle and the command queue to empty.
`default_nettype none

module adc_ladder_key_event_fsm_core #(
   parameter int unsigned NUM_KEYS = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [alke_pkg::VOLT_W-1:0]      req_ladder_mv,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic [1:0]                            rsp_event_kind,
   output logic [alke_pkg::KEY_W-1:0]            rsp_key_index,
   output logic                                  rsp_last,
   input  wire logic                             csr_we,
   input  wire logic [alke_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [alke_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import alke_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type q_head;

   // Accept a request while the queue has room
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   alke_front #(
      .NUM_KEYS (NUM_KEYS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .ladder_mv  (req_ladder_mv),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   alke_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   alke_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_event_kind (rsp_event_kind),
      .rsp_key_index  (rsp_key_index),
      .rsp_last       (rsp_last)
   );

endmodule : adc_ladder_key_event_fsm_core

`default_nettype wire
